// ===== src/crhp_pkg.sv =====
// shared types and constants for the coap response header parser
package crhp_pkg;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_CODE     = 3'd1;
    localparam logic [2:0] PH_ID_HI    = 3'd2;
    localparam logic [2:0] PH_ID_LO    = 3'd3;
    localparam logic [2:0] PH_TOKEN    = 3'd4;
    localparam logic [2:0] PH_OPT_HDR  = 3'd5;
    localparam logic [2:0] PH_OPT_DATA = 3'd6;
    localparam logic [2:0] PH_PAYLOAD  = 3'd7;

    localparam logic [1:0] KIND_CODE    = 2'd0;
    localparam logic [1:0] KIND_FORMAT  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [7:0] PAYLOAD_MARK = 8'hFF;
    localparam logic [3:0] FORMAT_DELTA = 4'hC;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] remaining;
        logic       is_format;
        logic       first_byte;
    } t_parse_state;

    typedef struct packed {
        logic       have;
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_result;

endpackage

// ===== src/crhp_if.sv =====
// valid/ready channel interfaces for datagram bytes and parse results
interface crhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface crhp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ===== src/crhp_step.sv =====
// per-byte next-state and result decode of the response parser
module crhp_step
    import crhp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_end,
    output t_parse_state o_state,
    output t_result      o_result
);

    t_parse_state n_state;
    t_result      n_result;
    logic [3:0]   w_dec;

    assign w_dec = i_state.remaining - 4'd1;

    always_comb begin
        n_state        = i_state;
        n_result.have  = 1'b0;
        n_result.kind  = KIND_CODE;
        n_result.value = 8'd0;
        n_result.last  = i_end;
        unique case (i_state.phase)
            PH_HEADER: begin
                n_state.remaining = i_byte[3:0];
                n_state.phase     = PH_CODE;
            end
            PH_CODE: begin
                n_result.have  = 1'b1;
                n_result.kind  = KIND_CODE;
                n_result.value = i_byte;
                n_state.phase  = PH_ID_HI;
            end
            PH_ID_HI: begin
                n_state.phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_state.phase = (i_state.remaining == 4'd0) ? PH_OPT_HDR : PH_TOKEN;
            end
            PH_TOKEN: begin
                n_state.remaining = w_dec;
                if (w_dec == 4'd0) begin
                    n_state.phase = PH_OPT_HDR;
                end
            end
            PH_OPT_HDR: begin
                if (i_byte == PAYLOAD_MARK) begin
                    n_state.phase = PH_PAYLOAD;
                end else begin
                    n_state.is_format  = (i_byte[7:4] == FORMAT_DELTA);
                    n_state.first_byte = 1'b1;
                    n_state.remaining  = i_byte[3:0];
                    n_state.phase = (i_byte[3:0] == 4'd0) ? PH_OPT_HDR : PH_OPT_DATA;
                end
            end
            PH_OPT_DATA: begin
                if (i_byte == PAYLOAD_MARK) begin
                    n_state.phase = PH_PAYLOAD;
                end else begin
                    if (i_state.is_format && i_state.first_byte) begin
                        n_result.have  = 1'b1;
                        n_result.kind  = KIND_FORMAT;
                        n_result.value = i_byte;
                    end
                    n_state.first_byte = 1'b0;
                    n_state.remaining  = w_dec;
                    if (w_dec == 4'd0) begin
                        n_state.phase = PH_OPT_HDR;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_result.have  = 1'b1;
                n_result.kind  = KIND_PAYLOAD;
                n_result.value = i_byte;
            end
            default: begin
                n_state.phase = PH_HEADER;
            end
        endcase

        // end of datagram: back to header phase, end marker if nothing else reported
        if (i_end) begin
            n_state.phase      = PH_HEADER;
            n_state.remaining  = 4'd0;
            n_state.is_format  = 1'b0;
            n_state.first_byte = 1'b0;
            if (!n_result.have) begin
                n_result.have  = 1'b1;
                n_result.kind  = KIND_END;
                n_result.value = 8'd0;
            end
        end
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

// ===== src/coap_response_header_parser.sv =====
// top level of the coap response header parser
//
//  channel  dir  payload                          transfer when
//  i_in     in   data_byte[8], end_of_datagram    i_in.valid & i_in.ready
//  o_out    out  kind[2], value[8], last          o_out.valid & o_out.ready
//
// one byte per cycle sustained while the sink keeps taking results; each
// byte is held in the input register, the parse decode sits between it and
// the result register, which holds the result until the sink takes it
// reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the header phase
// while a result waits in the output register the input register still
// takes one byte if it is empty; ready then drops until the sink takes the result
module coap_response_header_parser
    import crhp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    crhp_in_if.sink       i_in,
    crhp_out_if.source    o_out
);

    // input register stage
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_end;

    // parser state
    t_parse_state r_state;
    t_parse_state w_next_state;
    t_result      w_result;

    // result register
    logic         r_out_valid;
    logic [1:0]   r_out_kind;
    logic [7:0]   r_out_value;
    logic         r_out_last;

    logic         w_advance;
    logic         w_step;

    // the decode stage moves whenever the result register can take a value
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    crhp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_state  (w_next_state),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.end_of_datagram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_HEADER;
            r_state.remaining  <= 4'd0;
            r_state.is_format  <= 1'b0;
            r_state.first_byte <= 1'b0;
        end else if (w_step) begin
            r_state <= w_next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid && w_result.have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.have) begin
            r_out_kind  <= w_result.kind;
            r_out_value <= w_result.value;
            r_out_last  <= w_result.last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_out_kind;
    assign o_out.value = r_out_value;
    assign o_out.last  = r_out_last;

`ifndef SYNTH
    // a final byte always leaves a result flagged last
    a_end_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_in_end |=> r_out_valid && r_out_last)
        else $error("final byte did not produce a last result");

    // a final byte returns the parser to the header phase
    a_end_resets_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_in_end |=> r_state.phase == PH_HEADER && r_state.remaining == 4'd0)
        else $error("parser not back in header phase after final byte");

    // an end marker carries a zero value and the last flag
    a_end_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_END |-> r_out_value == 8'd0 && r_out_last)
        else $error("malformed end marker");

    // a result is only created from a byte held in the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !r_in_valid |=> !r_out_valid)
        else $error("result without a byte");
`endif

endmodule

// ===== tb/tb.sv =====
// testbench for the coap response header parser: byte stream stimulus, in-order result checks
module tb
    import crhp_pkg::*;
();

    // reference prediction of the parser plus the queue of reports still owed
    class response_scoreboard;
        logic [2:0] phase;
        logic [3:0] remaining;
        logic       is_format;
        logic       first_byte;
        t_result    pending_reports[$];
        int         mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            phase      = PH_HEADER;
            remaining  = '0;
            is_format  = 1'b0;
            first_byte = 1'b0;
        endfunction

        // advance the parse state by one accepted byte and queue its report
        function void take_byte(logic [7:0] b, logic eod);
            t_result r;
            r = '0;
            case (phase)
                PH_HEADER: begin
                    remaining = b[3:0];
                    phase     = PH_CODE;
                end
                PH_CODE: begin
                    r.have  = 1'b1;
                    r.kind  = KIND_CODE;
                    r.value = b;
                    phase   = PH_ID_HI;
                end
                PH_ID_HI: begin
                    phase = PH_ID_LO;
                end
                PH_ID_LO: begin
                    phase = (remaining == 0) ? PH_OPT_HDR : PH_TOKEN;
                end
                PH_TOKEN: begin
                    remaining = remaining - 4'd1;
                    if (remaining == 0) phase = PH_OPT_HDR;
                end
                PH_OPT_HDR: begin
                    if (b == PAYLOAD_MARK) begin
                        phase = PH_PAYLOAD;
                    end else begin
                        // only the raw delta nibble counts, no accumulation
                        is_format  = (b[7:4] == FORMAT_DELTA);
                        first_byte = 1'b1;
                        remaining  = b[3:0];
                        phase      = (remaining == 0) ? PH_OPT_HDR : PH_OPT_DATA;
                    end
                end
                PH_OPT_DATA: begin
                    if (b == PAYLOAD_MARK) begin
                        phase = PH_PAYLOAD;
                    end else begin
                        if (is_format && first_byte) begin
                            r.have  = 1'b1;
                            r.kind  = KIND_FORMAT;
                            r.value = b;
                        end
                        first_byte = 1'b0;
                        remaining  = remaining - 4'd1;
                        if (remaining == 0) phase = PH_OPT_HDR;
                    end
                end
                default: begin
                    r.have  = 1'b1;
                    r.kind  = KIND_PAYLOAD;
                    r.value = b;
                end
            endcase
            if (eod) begin
                clear();
                if (!r.have) begin
                    r.have  = 1'b1;
                    r.kind  = KIND_END;
                    r.value = '0;
                end
                r.last = 1'b1;
            end
            if (r.have) pending_reports.push_back(r);
        endfunction

        function void check_report(logic [1:0] kind, logic [7:0] value, logic last);
            t_result want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %02h last %0b",
                             kind, value, last);
            end else begin
                want = pending_reports.pop_front();
                if (want.kind !== kind || want.value !== value || want.last !== last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d/%02h/%0b got %0d/%02h/%0b",
                                 want.kind, want.value, want.last, kind, value, last);
                end
            end
        endfunction
    endclass

    localparam int BYTE_TARGET = 1550;
    localparam int IDLE_LIMIT  = 1000;

    logic i_clk;
    logic i_rst_n;

    crhp_in_if  in_ch();
    crhp_out_if out_ch();

    coap_response_header_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    response_scoreboard sb = new();

    logic [7:0] dgram[$];
    int         bytes_sent;
    int         send_run;
    bit         send_fast;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // gap before the next byte; stretches of back-to-back bytes mixed with idling
    function automatic int next_send_gap();
        if (send_run == 0) begin
            send_fast = ($urandom_range(0, 2) == 0);
            send_run  = $urandom_range(10, 60);
        end
        send_run--;
        return send_fast ? 0 : $urandom_range(0, 9);
    endfunction

    // offer one byte and hold it until the parser takes it
    task automatic send_byte(logic [7:0] b, logic eod);
        int gap;
        gap = next_send_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.end_of_datagram <= eod;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_byte(b, eod);
        bytes_sent++;
    endtask

    // send the queued datagram with the end mark on its final byte
    task automatic send_dgram();
        for (int i = 0; i < dgram.size(); i++)
            send_byte(dgram[i], i == dgram.size() - 1);
    endtask

    // hold the sender off until every owed report has been seen
    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // well-formed response with random content, sometimes noise or cut short
    task automatic build_response();
        logic [3:0] tkl;
        logic [3:0] delta;
        logic [3:0] olen;
        int         nopt;
        int         npay;
        int         style;
        dgram.delete();
        style = $urandom_range(0, 19);
        if (style < 2) begin
            // raw noise
            repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom()));
            return;
        end
        tkl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        dgram.push_back({4'($urandom()), tkl});
        dgram.push_back(8'($urandom()));
        dgram.push_back(8'($urandom()));
        dgram.push_back(8'($urandom()));
        repeat (tkl) dgram.push_back(8'($urandom()));
        nopt = $urandom_range(0, 4);
        repeat (nopt) begin
            delta = ($urandom_range(0, 2) == 0) ? FORMAT_DELTA : 4'($urandom());
            olen  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 15))
                                                : 4'($urandom_range(0, 4));
            dgram.push_back({delta, olen});
            for (int i = 0; i < olen; i++) begin
                // occasionally a marker inside option data cuts the option short
                if ($urandom_range(0, 39) == 0)
                    dgram.push_back(PAYLOAD_MARK);
                else
                    dgram.push_back(8'($urandom()));
            end
        end
        if ($urandom_range(0, 9) < 6) begin
            dgram.push_back(PAYLOAD_MARK);
            npay = $urandom_range(0, 10);
            repeat (npay) dgram.push_back(8'($urandom()));
        end
        if (style < 4) begin
            // truncated datagram
            while (dgram.size() > 1 && $urandom_range(0, 3) != 0) void'(dgram.pop_back());
        end
    endtask

    // result side: random ready stalls with stretches of constant ready
    initial begin
        int  stall;
        int  recv_run;
        bit  recv_fast;
        recv_run      = 0;
        recv_fast     = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (recv_run == 0) begin
                recv_fast = ($urandom_range(0, 2) == 0);
                recv_run  = $urandom_range(10, 60);
            end
            recv_run--;
            stall = recv_fast ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_report(out_ch.kind, out_ch.value, out_ch.last);
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int n_dgrams;
        bytes_sent = 0;
        send_run   = 0;
        send_fast  = 1'b0;
        n_dgrams   = 0;

        // every input known from the start, reset held low first
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.data_byte       <= '0;
        in_ch.end_of_datagram <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single header byte that ends the datagram: end marker only
        dgram = '{8'h00};
        send_dgram();

        // id bytes of all ones are plain data, format option with and without
        // data, non-format delta 13, then payload ending on a payload byte
        dgram = '{8'hF0, 8'h45, 8'hFF, 8'hFF, 8'hC1, 8'h32, 8'hC0, 8'hD1, 8'h00,
                  8'hFF, 8'hAB};
        send_dgram();

        // marker inside the token is skipped, marker in option data starts
        // the payload early, datagram ends on the payload
        dgram = '{8'h52, 8'h84, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hC3, 8'hFF, 8'hFF};
        send_dgram();

        // truncated after the code: code report carries the end flag
        dgram = '{8'h0F, 8'h00};
        send_dgram();

        // ends on the payload marker: end marker
        dgram = '{8'h40, 8'h01, 8'h00, 8'h00, 8'hFF};
        send_dgram();
        drain_reports();

        while (bytes_sent < BYTE_TARGET) begin
            build_response();
            send_dgram();
            n_dgrams++;
            if (n_dgrams % 30 == 0) drain_reports();
        end
        in_ch.valid <= 1'b0;

        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/crhp_pkg.sv
src/crhp_if.sv
src/crhp_step.sv
src/coap_response_header_parser.sv
tb/tb.sv
